// File: src/bce_pkg.sv
`timescale 1ns / 1ps
package bce_pkg;

    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;

    localparam logic [7:0] CMD_W = 8'h57;
    localparam logic [7:0] CMD_R = 8'h52;
    localparam logic [7:0] CMD_B = 8'h42;
    localparam logic [7:0] CMD_X = 8'h58;
    localparam logic [7:0] CMD_S = 8'h53;

    localparam int BUF_DEPTH = 67;
    localparam logic [6:0] LAST_DATA_IDX = 7'd66;
    localparam logic [6:0] LAST_SUM_IDX = 7'd65;
    localparam logic [6:0] COPY_STEPS = 7'd64;
    localparam logic [6:0] FIRST_DATA_IDX = 7'd2;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_LAUNCH = 2'd1;
    localparam logic [1:0] ACT_SUPPLY = 2'd2;
    localparam logic [1:0] ACT_TONE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEN,
        ST_EXEC,
        ST_WCOPY,
        ST_WACK,
        ST_RRD,
        ST_RWORD,
        ST_RSUM,
        ST_SACK2
    } bce_state_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] byte_count;
        logic [1:0] action;
        logic [7:0] tone_half_period;
        logic [7:0] tone_count_high;
        logic       last;
    } bce_result_t;

    function automatic logic [6:0] len_of(input logic [7:0] code);
        logic [6:0] len;
        begin
            unique case (code)
                CMD_W:   len = 7'd67;
                CMD_R:   len = 7'd2;
                CMD_B:   len = 7'd1;
                CMD_X:   len = 7'd1;
                CMD_S:   len = 7'd3;
                default: len = 7'd0;
            endcase
            return len;
        end
    endfunction

endpackage

// File: src/bce_in_if.sv
`timescale 1ns / 1ps
interface bce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/bce_out_if.sv
`timescale 1ns / 1ps
interface bce_out_if;
    import bce_pkg::*;
    logic        valid;
    logic        ready;
    bce_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/bce_cmd_buf.sv
`timescale 1ns / 1ps
module bce_cmd_buf (
    input  logic       clk,
    input  logic       we,
    input  logic [6:0] waddr,
    input  logic [7:0] wdata,
    input  logic       re,
    input  logic [6:0] raddr,
    output logic [7:0] rdata
);
    import bce_pkg::*;

    logic [7:0] mem [BUF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: src/bce_flash.sv
`timescale 1ns / 1ps
module bce_flash #(
    parameter int DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [13:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [13:0]   rdata,
    output logic          busy
);
    logic [13:0]   mem [DEPTH];
    logic [AW-1:0] clr_addr_reg;
    logic          busy_reg;

    // sweep every entry to the erased value after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= 14'h3FFF;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

    assign busy = busy_reg;
endmodule

// File: src/boot_command_engine.sv
`timescale 1ns / 1ps
// Byte-level command engine of a serial bootloader.
// Input channel: one received byte per word. Output channel: one response
// word per result, carrying one or two bytes, an action request and a last
// flag on the final result of each input byte.
// A command byte gets its length answer; data bytes are collected into a
// 67-entry command buffer and the command runs on the final one.
// One input byte is taken every cycle the engine is idle. A page write
// copies 64 buffer bytes into flash through the single buffer read port.
// A page read reads each flash word and then presents it, for 34 results
// in all. At reset the flash array is swept to the erased value, one word
// per cycle; no byte is accepted during the sweep.
// When the receiver stalls, the current result holds in the output register
// and the engine waits at its next result, taking no byte; bytes that
// complete no command are still taken while the engine sits idle.
module boot_command_engine #(
    parameter int FLASH_PAGES = 128
) (
    input  logic clk,
    input  logic rst_n,
    bce_in_if.sink   in,
    bce_out_if.source out
);
    import bce_pkg::*;

    localparam int PAGE_WORDS = 32;
    localparam int PW = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
    localparam int AW = PW + 5;
    localparam int DEPTH = FLASH_PAGES * PAGE_WORDS;

    function automatic logic [PW-1:0] page_of(input logic [7:0] b);
        logic [15:0] r;
        begin
            r = {8'd0, b};
            for (int k = 7; k >= 0; k--)
            begin
                if (r >= (16'(FLASH_PAGES) << k))
                begin
                    r = r - (16'(FLASH_PAGES) << k);
                end
            end
            return r[PW-1:0];
        end
    endfunction

    bce_state_t  state_reg, state_next;
    logic [7:0]  code_reg;
    logic [6:0]  len_reg;
    logic        run_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  idx_reg;
    logic [7:0]  page_reg;
    logic [PW-1:0] pidx_reg;
    logic [7:0]  b2_reg;
    logic [7:0]  sum_reg;
    logic        mism_reg;
    logic [6:0]  t_reg;
    logic [4:0]  i_reg;
    logic [5:0]  hi_reg;
    logic        out_valid_reg;
    bce_result_t out_data_reg;

    logic        accept;
    logic        slot_free;
    logic        emit;
    bce_result_t res;
    logic        flash_busy;
    logic [13:0] flash_rdata;
    logic [7:0]  buf_rdata;
    logic [6:0]  t_m1;
    logic [6:0]  len_in;

    assign slot_free = !out_valid_reg || out.ready;
    assign in.ready  = (state_reg == ST_IDLE);
    assign accept    = in.valid && in.ready;
    assign t_m1      = t_reg - 7'd1;
    assign len_in    = len_of(in.rx_byte);

    bce_cmd_buf u_buf (
        .clk   (clk),
        .we    (accept && rem_reg != 7'd0 && idx_reg < 7'(BUF_DEPTH)),
        .waddr (idx_reg),
        .wdata (in.rx_byte),
        .re    (state_reg == ST_WCOPY && t_reg < COPY_STEPS),
        .raddr (t_reg + FIRST_DATA_IDX),
        .rdata (buf_rdata)
    );

    bce_flash #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_flash (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (state_reg == ST_WCOPY && t_reg != 7'd0 && !t_reg[0]),
        .waddr ({pidx_reg, t_m1[5:1]}),
        .wdata ({hi_reg, buf_rdata}),
        .re    (state_reg == ST_RRD),
        .raddr ({pidx_reg, i_reg}),
        .rdata (flash_rdata),
        .busy  (flash_busy)
    );

    // result to load into the output register this cycle
    always_comb
    begin
        emit = 1'b0;
        res  = '0;
        res.byte_count = 2'd1;
        unique case (state_reg)
            ST_LEN:
            begin
                emit = slot_free;
                res.first_byte = {1'b0, len_reg};
                res.last = !run_reg;
            end
            ST_EXEC:
            begin
                unique case (code_reg)
                    CMD_B:
                    begin
                        emit = slot_free;
                        res.first_byte = CODE_ACK;
                        res.action = ACT_SUPPLY;
                        res.last = 1'b1;
                    end
                    CMD_X:
                    begin
                        emit = slot_free;
                        res.first_byte = CODE_ACK;
                        res.action = ACT_LAUNCH;
                        res.last = 1'b1;
                    end
                    CMD_S:
                    begin
                        emit = slot_free;
                        res.first_byte = CODE_ACK;
                        res.action = ACT_TONE;
                        res.tone_half_period = page_reg;
                        res.tone_count_high = b2_reg;
                    end
                    CMD_R:
                    begin
                        emit = slot_free;
                        res.first_byte = CODE_ACK;
                    end
                    CMD_W:
                    begin
                        emit = slot_free && mism_reg;
                        res.first_byte = CODE_NAK;
                        res.second_byte = sum_reg;
                        res.byte_count = 2'd2;
                        res.last = 1'b1;
                    end
                    default:
                    begin
                        emit = slot_free;
                        res.first_byte = CODE_NAK;
                        res.last = 1'b1;
                    end
                endcase
            end
            ST_WACK, ST_SACK2:
            begin
                emit = slot_free;
                res.first_byte = CODE_ACK;
                res.last = 1'b1;
            end
            ST_RWORD:
            begin
                emit = slot_free;
                res.first_byte = {2'b00, flash_rdata[13:8]};
                res.second_byte = flash_rdata[7:0];
                res.byte_count = 2'd2;
            end
            ST_RSUM:
            begin
                emit = slot_free;
                res.first_byte = sum_reg;
                res.last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!flash_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (rem_reg == 7'd0)
                    begin
                        state_next = ST_LEN;
                    end
                    else if (rem_reg == 7'd1)
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_LEN:
            begin
                if (emit)
                begin
                    state_next = run_reg ? ST_EXEC : ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                if (code_reg == CMD_W && !mism_reg)
                begin
                    if (slot_free)
                    begin
                        state_next = ST_WCOPY;
                    end
                end
                else if (emit)
                begin
                    if (code_reg == CMD_S)
                    begin
                        state_next = ST_SACK2;
                    end
                    else if (code_reg == CMD_R)
                    begin
                        state_next = ST_RRD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WCOPY:
            begin
                if (t_reg == COPY_STEPS)
                begin
                    state_next = ST_WACK;
                end
            end
            ST_RRD:
            begin
                state_next = ST_RWORD;
            end
            ST_RWORD:
            begin
                if (emit)
                begin
                    state_next = (i_reg == 5'd31) ? ST_RSUM : ST_RRD;
                end
            end
            ST_WACK, ST_SACK2, ST_RSUM:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rem_reg       <= '0;
            idx_reg       <= '0;
            code_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                if (rem_reg == 7'd0)
                begin
                    code_reg <= in.rx_byte;
                    idx_reg  <= 7'd1;
                    rem_reg  <= (len_in == 7'd0) ? 7'd0 : len_in - 7'd1;
                end
                else
                begin
                    idx_reg <= idx_reg + 7'd1;
                    rem_reg <= rem_reg - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= res;
        end
        if (accept)
        begin
            if (rem_reg == 7'd0)
            begin
                len_reg <= len_in;
                run_reg <= (len_in == 7'd1);
            end
            else
            begin
                if (idx_reg == 7'd1)
                begin
                    page_reg <= in.rx_byte;
                    pidx_reg <= page_of(in.rx_byte);
                    sum_reg  <= in.rx_byte;
                end
                else if (idx_reg <= LAST_SUM_IDX)
                begin
                    sum_reg <= sum_reg + in.rx_byte;
                end
                if (idx_reg == 7'd2)
                begin
                    b2_reg <= in.rx_byte;
                end
                if (idx_reg == LAST_DATA_IDX)
                begin
                    mism_reg <= (sum_reg != in.rx_byte);
                end
            end
        end
        if (state_reg == ST_EXEC)
        begin
            t_reg <= '0;
            i_reg <= '0;
            if (code_reg == CMD_R)
            begin
                sum_reg <= page_reg;
            end
        end
        if (state_reg == ST_WCOPY)
        begin
            t_reg <= t_reg + 7'd1;
            if (t_reg[0])
            begin
                hi_reg <= buf_rdata[5:0];
            end
        end
        if (state_reg == ST_RWORD && emit)
        begin
            i_reg   <= i_reg + 5'd1;
            sum_reg <= sum_reg + {2'b00, flash_rdata[13:8]} + flash_rdata[7:0];
        end
    end

    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out.ready))
        else $error("result loaded over an untaken result");

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !flash_busy)
        else $error("byte accepted during flash clear");

    a_word_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RWORD) |-> ($past(state_reg) == ST_RRD
            || $past(state_reg) == ST_RWORD))
        else $error("flash word presented without a read");
`endif
endmodule
